// ----- src/u16u8_pkg.sv -----
// Shared types, register addresses and the UTF-8 encoder for the UTF-16LE to UTF-8 converter.
package u16u8_pkg;

  // Configuration register word indexes, taken from paddr[2].
  localparam logic REG_BYTE_MODE = 1'b0;
  localparam logic REG_SEPARATOR = 1'b1;

  // Depth of the job queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified input item: up to four data bytes, then an optional final result.
  // A final result is the terminator, or the error result when bad is set.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            term;
    logic            bad;
  } u16u8_job_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic empty;
    logic full;
  } u16u8_qstat_t;

  // Encode one code point as one to four UTF-8 bytes.
  function automatic u16u8_job_t encode_cp(input logic [20:0] cp);
    u16u8_job_t j;
    j = '0;
    if (cp < 21'h00080) begin
      j.bytes[0] = cp[7:0];
      j.count    = 3'd1;
    end else if (cp < 21'h00800) begin
      j.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      j.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      j.count    = 3'd2;
    end else if (cp < 21'h10000) begin
      j.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      j.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      j.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      j.count    = 3'd3;
    end else begin
      j.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      j.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      j.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      j.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      j.count    = 3'd4;
    end
    return j;
  endfunction

endpackage

// ----- src/u16u8_front.sv -----
// Front part: accepts code units, tracks surrogate pairs and classifies each unit into a job.
module u16u8_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_mode,
  input  logic [7:0]              separator,
  input  logic [15:0]             code_unit,
  input  logic                    last_unit,
  input  logic                    accept,
  output logic                    push,
  output u16u8_pkg::u16u8_job_t   job
);
  import u16u8_pkg::*;

  logic        pair_pending;
  logic        pair_pending_next;
  logic [9:0]  high_half_bits;
  logic [9:0]  high_half_bits_next;
  logic        has_job;
  logic [7:0]  b;
  logic [15:0] cu;
  logic [20:0] cp_pair;

  assign cp_pair = 21'h10000 + {1'b0, high_half_bits, code_unit[9:0]};

  // Classify the unit under the mode in force now.
  always_comb begin
    job                 = '0;
    has_job             = 1'b0;
    pair_pending_next   = pair_pending;
    high_half_bits_next = high_half_bits;
    b                   = code_unit[7:0];
    cu                  = code_unit;
    if (byte_mode) begin
      if (b == 8'h00 && !last_unit) begin
        b = separator;
      end
      job.bytes[0]        = b;
      job.count           = 3'd1;
      job.term            = last_unit;
      has_job             = 1'b1;
      pair_pending_next   = 1'b0;
      high_half_bits_next = '0;
    end else if (pair_pending) begin
      job                 = encode_cp(cp_pair);
      job.term            = last_unit;
      has_job             = 1'b1;
      pair_pending_next   = 1'b0;
      high_half_bits_next = '0;
    end else begin
      if (cu == 16'h0000 && !last_unit) begin
        cu = {8'h00, separator};
      end
      if (cu[15:11] == 5'b11011) begin
        // Any surrogate is taken as the first half of a pair: hold it, or report a cut-off pair.
        if (last_unit) begin
          job.term = 1'b1;
          job.bad  = 1'b1;
          has_job  = 1'b1;
        end else begin
          pair_pending_next   = 1'b1;
          high_half_bits_next = cu[9:0];
        end
      end else begin
        job      = encode_cp({5'b00000, cu});
        job.term = last_unit;
        has_job  = 1'b1;
      end
    end
  end

  assign push = accept && has_job;

  // Pair state advances only on an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_pending   <= 1'b0;
      high_half_bits <= '0;
    end else if (accept) begin
      pair_pending   <= pair_pending_next;
      high_half_bits <= high_half_bits_next;
    end
  end

endmodule

// ----- src/u16u8_queue.sv -----
// Short job queue between the front and back parts.
module u16u8_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  u16u8_pkg::u16u8_job_t   push_job,
  input  logic                    pop,
  output u16u8_pkg::u16u8_job_t   head,
  output u16u8_pkg::u16u8_qstat_t stat
);
  import u16u8_pkg::*;

  u16u8_job_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- src/u16u8_back.sv -----
// Back part: walks each job byte by byte into the output register.
module u16u8_back (
  input  logic                    clk,
  input  logic                    rst,
  input  u16u8_pkg::u16u8_job_t   head,
  input  u16u8_pkg::u16u8_qstat_t stat,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [7:0]              m_tdata,
  output logic                    m_tlast,
  output logic                    m_tuser
);
  import u16u8_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic       is_final;
  logic       is_data;
  logic       load;

  assign total    = head.count + {2'b00, head.term};
  assign is_final = (idx + 3'd1) == total;
  assign is_data  = idx < head.count;
  assign load     = !stat.empty && (!m_tvalid || m_tready);
  assign pop      = load && is_final;

  // Result index within the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= is_final ? 3'd0 : idx + 3'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= is_data ? head.bytes[idx[1:0]] : 8'h00;
      m_tlast <= !is_data;
      m_tuser <= !is_data && head.bad;
    end
  end

endmodule

// ----- src/utf16le_to_utf8_string_converter.sv -----
// Top level of the UTF-16LE to UTF-8 string converter with its configuration registers.
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   s_tdata = code_unit, s_tlast = last_unit
//  m_*       out        m_tvalid/m_tready   m_tdata = out_byte, m_tlast = end_of_string,
//                                           m_tuser = bad_pair
//  APB       in         psel/penable        0x0 byte_mode, 0x4 separator
//
// One input request is taken per cycle while the four-entry job queue has room.
// The back part sends each job's results one at a time, so a unit yields zero to five
// output results; the output register sets the sustained rate.
// Reset clears pair state, the queue and output valid; the configuration registers reset to zero.
// Stalls on m_tready fill the queue and then drop s_tready.
module utf16le_to_utf8_string_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic        m_tuser,   // [0] bad_pair
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import u16u8_pkg::*;

  logic         byte_mode;
  logic [7:0]   separator;
  logic         accept;
  logic         push;
  logic         pop;
  u16u8_job_t   job;
  u16u8_job_t   head;
  u16u8_qstat_t stat;

  assign pready   = 1'b1;
  assign s_tready = !stat.full;
  assign accept   = s_tvalid && s_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_mode <= 1'b0;
      separator <= 8'h00;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_BYTE_MODE: byte_mode <= pwdata[0];
        REG_SEPARATOR: separator <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[2])
      REG_BYTE_MODE: prdata = {31'b0, byte_mode};
      REG_SEPARATOR: prdata = {24'b0, separator};
      default:       prdata = '0;
    endcase
  end

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_mode (byte_mode),
    .separator (separator),
    .code_unit (s_tdata),
    .last_unit (s_tlast),
    .accept    (accept),
    .push      (push),
    .job       (job)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  u16u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- src/u16u8_checker.sv -----
// Port-level checks for the converter, bound to the top level.
module u16u8_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // A stalled output request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output request changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // An error result always closes the string.
  a_bad_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error result without end of string");

  // The closing result of a string always carries a zero byte.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == 8'h00)
    else $error("end of string with nonzero byte");

endmodule

bind utf16le_to_utf8_string_converter u16u8_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
